[rtl/core/lubd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lubd_pkg
// Shared codes and widths for the LED / serial bytecode dispatcher.
// ----------------------------------------------------------------------------
package lubd_pkg;

    localparam int BYTE_W    = 8;
    localparam int ACTION_W  = 2;
    localparam int CAUSE_W   = 3;
    localparam int PHASE_W   = 3;
    // red, green, blue, tx_data, stop_cause packed and padded to whole bytes
    localparam int OUT_DATA_W = 40;

    // opcodes
    localparam logic [BYTE_W-1:0] OP_HALT_A = 8'h00;
    localparam logic [BYTE_W-1:0] OP_HALT_B = 8'hAA;
    localparam logic [BYTE_W-1:0] OP_LED    = 8'h01;
    localparam logic [BYTE_W-1:0] OP_TX     = 8'h03;
    localparam logic [BYTE_W:0]   LED_BYTES = 9'd3;

    // result kinds
    localparam logic [ACTION_W-1:0] ACT_NONE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_LED  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_TX   = 2'd2;

    // stop causes
    localparam logic [CAUSE_W-1:0] CAUSE_RUN     = 3'd0;
    localparam logic [CAUSE_W-1:0] CAUSE_HALT    = 3'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_UNKNOWN = 3'd2;
    localparam logic [CAUSE_W-1:0] CAUSE_TRUNC   = 3'd3;
    localparam logic [CAUSE_W-1:0] CAUSE_END     = 3'd4;

    // decoder phases
    localparam logic [PHASE_W-1:0] PH_OPCODE = 3'd0;
    localparam logic [PHASE_W-1:0] PH_RED    = 3'd1;
    localparam logic [PHASE_W-1:0] PH_GREEN  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_BLUE   = 3'd3;
    localparam logic [PHASE_W-1:0] PH_TXLEN  = 3'd4;
    localparam logic [PHASE_W-1:0] PH_TXDATA = 3'd5;

endpackage

[rtl/core/led_uart_bytecode_dispatcher_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_uart_bytecode_dispatcher_unit
// Decodes a byte stream of LED fill and serial transmit commands.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one program byte per beat (tdata) with a start-of-program
//   flag (tuser) that restarts decoding at position zero. m_axis returns
//   exactly one result beat per input beat: tuser is the action (none, LED
//   fill, transmit byte), tdata holds colour, transmit byte and stop cause,
//   tlast marks the beat that ends dispatch.
//   cfg_wr_en / cfg_wr_data load the program length; write it only while
//   no beats are in flight.
// Timing:
//   A beat passes an input register, then the decode step, which updates
//   the dispatcher state as it loads the result register. One beat per
//   cycle is sustained while m_axis_tready is high.
// Reset:
//   rst_n clears the pipeline valids, the program length and the decoder,
//   which then runs at position zero as if a program had just started.
// Stall:
//   When m_axis_tready is low the result register holds, the input
//   register fills behind it, and s_axis_tready drops until space frees.
// ----------------------------------------------------------------------------
module led_uart_bytecode_dispatcher_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration
    input  logic                             cfg_wr_en,
    input  logic [lubd_pkg::BYTE_W-1:0]      cfg_wr_data,   // program_length
    // input stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [lubd_pkg::BYTE_W-1:0]      s_axis_tdata,  // [7:0] prog_byte
    input  logic                             s_axis_tuser,  // first_of_program
    // result stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [7:0] red, [15:8] green, [23:16] blue, [31:24] tx_data,
    // [34:32] stop_cause, [39:35] zero
    output logic [lubd_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    output logic [lubd_pkg::ACTION_W-1:0]    m_axis_tuser,  // [1:0] action
    output logic                             m_axis_tlast   // finished
);
    import lubd_pkg::*;

    // configuration register
    logic [BYTE_W-1:0] prog_len_reg;

    // input register
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_first_reg;

    // dispatcher state
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [BYTE_W-1:0]  pos_reg, pos_next;
    logic [BYTE_W-1:0]  rem_reg, rem_next;
    logic [BYTE_W-1:0]  red_hold_reg, red_hold_next;
    logic [BYTE_W-1:0]  green_hold_reg, green_hold_next;
    logic               stopped_reg, stopped_next;

    // result register
    logic                out_valid_reg;
    logic [ACTION_W-1:0] action_reg, action_next;
    logic [BYTE_W-1:0]   red_reg, red_next;
    logic [BYTE_W-1:0]   green_reg, green_next;
    logic [BYTE_W-1:0]   blue_reg, blue_next;
    logic [BYTE_W-1:0]   tx_reg, tx_next;
    logic                fin_reg, fin_next;
    logic [CAUSE_W-1:0]  cause_reg, cause_next;

    // handshake
    logic advance;
    logic in_take;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    // effective state after a start mark
    logic [PHASE_W-1:0] ph_eff;
    logic [BYTE_W-1:0]  pos_eff;
    logic [BYTE_W-1:0]  rem_eff;
    logic               stop_eff;
    logic [BYTE_W-1:0]  pos_inc;
    logic [BYTE_W:0]    led_end;
    logic [BYTE_W:0]    tx_end;
    logic [BYTE_W:0]    len_ext;

    always_comb
    begin
        ph_eff   = in_first_reg ? PH_OPCODE : phase_reg;
        pos_eff  = in_first_reg ? '0 : pos_reg;
        rem_eff  = in_first_reg ? '0 : rem_reg;
        stop_eff = in_first_reg ? 1'b0 : stopped_reg;
        pos_inc  = pos_eff + 8'd1;
        len_ext  = {1'b0, prog_len_reg};
        led_end  = {1'b0, pos_inc} + LED_BYTES;
        tx_end   = {1'b0, pos_inc} + {1'b0, in_byte_reg};
    end

    // decode step
    always_comb
    begin
        phase_next      = ph_eff;
        pos_next        = pos_eff;
        rem_next        = rem_eff;
        red_hold_next   = red_hold_reg;
        green_hold_next = green_hold_reg;
        stopped_next    = stop_eff;
        action_next     = ACT_NONE;
        red_next        = '0;
        green_next      = '0;
        blue_next       = '0;
        tx_next         = '0;
        fin_next        = 1'b0;
        cause_next      = CAUSE_RUN;

        if (!stop_eff)
        begin
            case (ph_eff)
                PH_OPCODE:
                begin
                    if (pos_eff >= prog_len_reg)
                    begin
                        stopped_next = 1'b1;
                        fin_next     = 1'b1;
                        cause_next   = CAUSE_END;
                    end
                    else
                    begin
                        pos_next = pos_inc;
                        if (in_byte_reg == OP_HALT_A || in_byte_reg == OP_HALT_B)
                        begin
                            stopped_next = 1'b1;
                            fin_next     = 1'b1;
                            cause_next   = CAUSE_HALT;
                        end
                        else if (in_byte_reg == OP_LED)
                        begin
                            if (led_end > len_ext)
                            begin
                                stopped_next = 1'b1;
                                fin_next     = 1'b1;
                                cause_next   = CAUSE_TRUNC;
                            end
                            else
                            begin
                                phase_next = PH_RED;
                            end
                        end
                        else if (in_byte_reg == OP_TX)
                        begin
                            if (pos_inc >= prog_len_reg)
                            begin
                                stopped_next = 1'b1;
                                fin_next     = 1'b1;
                                cause_next   = CAUSE_TRUNC;
                            end
                            else
                            begin
                                phase_next = PH_TXLEN;
                            end
                        end
                        else
                        begin
                            stopped_next = 1'b1;
                            fin_next     = 1'b1;
                            cause_next   = CAUSE_UNKNOWN;
                        end
                    end
                end
                PH_RED:
                begin
                    red_hold_next = in_byte_reg;
                    pos_next      = pos_inc;
                    phase_next    = PH_GREEN;
                end
                PH_GREEN:
                begin
                    green_hold_next = in_byte_reg;
                    pos_next        = pos_inc;
                    phase_next      = PH_BLUE;
                end
                PH_BLUE:
                begin
                    pos_next    = pos_inc;
                    action_next = ACT_LED;
                    red_next    = red_hold_reg;
                    green_next  = green_hold_reg;
                    blue_next   = in_byte_reg;
                    phase_next  = PH_OPCODE;
                    if (pos_inc >= prog_len_reg)
                    begin
                        stopped_next = 1'b1;
                        fin_next     = 1'b1;
                        cause_next   = CAUSE_END;
                    end
                end
                PH_TXLEN:
                begin
                    pos_next = pos_inc;
                    if (tx_end > len_ext)
                    begin
                        stopped_next = 1'b1;
                        fin_next     = 1'b1;
                        cause_next   = CAUSE_TRUNC;
                        phase_next   = PH_OPCODE;
                    end
                    else if (in_byte_reg == '0)
                    begin
                        // empty transmit completes on its length byte
                        phase_next = PH_OPCODE;
                        if (pos_inc >= prog_len_reg)
                        begin
                            stopped_next = 1'b1;
                            fin_next     = 1'b1;
                            cause_next   = CAUSE_END;
                        end
                    end
                    else
                    begin
                        rem_next   = in_byte_reg;
                        phase_next = PH_TXDATA;
                    end
                end
                PH_TXDATA:
                begin
                    pos_next    = pos_inc;
                    action_next = ACT_TX;
                    tx_next     = in_byte_reg;
                    rem_next    = rem_eff - 8'd1;
                    if (rem_eff == 8'd1)
                    begin
                        phase_next = PH_OPCODE;
                        if (pos_inc >= prog_len_reg)
                        begin
                            stopped_next = 1'b1;
                            fin_next     = 1'b1;
                            cause_next   = CAUSE_END;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_OPCODE;
                end
            endcase
        end
    end

    // configuration and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prog_len_reg   <= '0;
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            phase_reg      <= PH_OPCODE;
            pos_reg        <= '0;
            rem_reg        <= '0;
            red_hold_reg   <= '0;
            green_hold_reg <= '0;
            stopped_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                prog_len_reg <= cfg_wr_data;
            end
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg  <= 1'b1;
                phase_reg      <= phase_next;
                pos_reg        <= pos_next;
                rem_reg        <= rem_next;
                red_hold_reg   <= red_hold_next;
                green_hold_reg <= green_hold_next;
                stopped_reg    <= stopped_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg  <= s_axis_tdata;
            in_first_reg <= s_axis_tuser;
        end
        if (advance)
        begin
            action_reg <= action_next;
            red_reg    <= red_next;
            green_reg  <= green_next;
            blue_reg   <= blue_next;
            tx_reg     <= tx_next;
            fin_reg    <= fin_next;
            cause_reg  <= cause_next;
        end
    end

    // result port
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = action_reg;
    assign m_axis_tlast  = fin_reg;
    assign m_axis_tdata  = {5'd0, cause_reg, tx_reg, blue_reg, green_reg, red_reg};

`ifndef SYNTH
    // a finishing beat always carries a cause, a running beat never does
    a_fin_cause: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> cause_reg != CAUSE_RUN)
        else $error("finished beat without stop cause");

    a_run_cause: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> cause_reg == CAUSE_RUN)
        else $error("stop cause on a running beat");

    // a stopped decoder without a restart emits nothing
    a_quiet_stop: assert property (@(posedge clk) disable iff (!rst_n)
        advance && stopped_reg && !in_first_reg |=>
            action_reg == ACT_NONE && !fin_reg)
        else $error("output after stop");

    // a finishing step leaves the decoder stopped
    a_fin_stops: assert property (@(posedge clk) disable iff (!rst_n)
        advance && fin_next |=> stopped_reg)
        else $error("finish did not stop decoder");
`endif

endmodule
